[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Each check is clocked on the rising edge
// and is switched off while the reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: property does not hold");

// A condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");

`else

`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

[hw/rtl/dssu_pkg.sv]
package dssu_pkg;

   localparam int MAX_END_TOKENS = 4;

   localparam int TOKEN_W    = 32;
   localparam int COUNT_W    = 32;
   localparam int LEN_W      = 20;
   localparam int TOTAL_W    = 11;
   localparam int END_CNT_W  = 3;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [LEN_W-1:0]          LEN_MAX   = '1;
   localparam logic [COUNT_W-1:0]        COUNT_MAX = '1;
   localparam logic [TOTAL_W-1:0]        TOTAL_MAX = '1;
   localparam logic signed [TOKEN_W-1:0] NO_TOKEN  = '1;

   localparam logic [END_CNT_W-1:0] END_COUNT_RESET = 3'd1;
   localparam logic [TOTAL_W-1:0]   THRESHOLD_RESET = 11'd1024;

   // Register indexes, at byte address four times the index.
   localparam logic [REG_IDX_W-1:0] REG_END_TOKEN_0    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_END_TOKEN_1    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_END_TOKEN_2    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_END_TOKEN_3    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_END_COUNT      = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_STOP_THRESHOLD = 3'd5;

   typedef struct packed {
      logic [COUNT_W-1:0]        step_count;
      logic [COUNT_W-1:0]        max_length;
      logic                      stop_in;
      logic [LEN_W-1:0]          this_time_len;
      logic [LEN_W-1:0]          encoder_len;
      logic [LEN_W-1:0]          decoder_len;
      logic signed [TOKEN_W-1:0] sampled_token;
      logic signed [TOKEN_W-1:0] prev_echo_token;
      logic                      block_step;
      logic                      slot_active;
      logic                      last_slot;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]        step_count_out;
      logic                      stop_out;
      logic signed [TOKEN_W-1:0] next_token_out;
      logic signed [TOKEN_W-1:0] echo_token_out;
      logic [LEN_W-1:0]          this_time_len_out;
      logic [LEN_W-1:0]          encoder_len_out;
      logic [LEN_W-1:0]          decoder_len_out;
      logic                      keep_going;
      logic                      last_out;
   } rsp_type;

   typedef struct packed {
      logic [MAX_END_TOKENS-1:0][TOKEN_W-1:0] end_token;
      logic [END_CNT_W-1:0]                   end_count;
      logic [TOTAL_W-1:0]                     stop_threshold;
   } cfg_type;

endpackage

[hw/rtl/dssu_slot.sv]
module dssu_slot
   import dssu_pkg::*;
(
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp,
   output logic    stop_add
);

   logic [COUNT_W-1:0]        step_next;
   logic                      stop_len;
   logic                      stop_fin;
   logic                      end_hit;
   logic [END_CNT_W-1:0]      end_used;
   logic signed [TOKEN_W-1:0] next_tok;
   logic signed [TOKEN_W-1:0] echo_tok;
   logic [LEN_W:0]            len_sum;

   always_comb begin
      if (!req.stop_in && req.step_count != COUNT_MAX) begin
         step_next = req.step_count + COUNT_W'(1);
      end else begin
         step_next = req.step_count;
      end
      stop_len = req.stop_in || (step_next >= req.max_length);
   end

   // A stopped slot that took no tokens this step keeps its echo and feeds none back.
   always_comb begin
      next_tok = NO_TOKEN;
      echo_tok = req.prev_echo_token;
      if (stop_len) begin
         if (req.this_time_len != '0) begin
            next_tok = $signed(cfg.end_token[0]);
            echo_tok = $signed(cfg.end_token[0]);
         end
      end else begin
         next_tok = req.sampled_token;
         echo_tok = req.sampled_token;
      end
   end

   always_comb begin
      if (cfg.end_count > END_CNT_W'(MAX_END_TOKENS)) begin
         end_used = END_CNT_W'(MAX_END_TOKENS);
      end else begin
         end_used = cfg.end_count;
      end
      end_hit = 1'b0;
      for (int i = 0; i < MAX_END_TOKENS; i++) begin
         if (END_CNT_W'(i) < end_used && cfg.end_token[i] == next_tok) begin
            end_hit = 1'b1;
         end
      end
   end

   assign stop_fin = stop_len || end_hit;
   assign len_sum  = {1'b0, req.encoder_len} + {1'b0, req.decoder_len};

   always_comb begin
      rsp.step_count_out    = step_next;
      rsp.stop_out          = stop_len;
      rsp.next_token_out    = NO_TOKEN;
      rsp.echo_token_out    = req.prev_echo_token;
      rsp.this_time_len_out = req.this_time_len;
      rsp.encoder_len_out   = req.encoder_len;
      rsp.decoder_len_out   = req.decoder_len;
      rsp.keep_going        = 1'b0;
      rsp.last_out          = req.last_slot;
      stop_add              = 1'b1;
      if (req.slot_active) begin
         rsp.stop_out        = stop_fin;
         rsp.next_token_out  = next_tok;
         rsp.echo_token_out  = echo_tok;
         rsp.encoder_len_out = '0;
         if (stop_fin) begin
            rsp.decoder_len_out   = '0;
            rsp.this_time_len_out = '0;
         end else begin
            rsp.this_time_len_out = LEN_W'(1);
            if (req.encoder_len != '0) begin
               rsp.decoder_len_out = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
            end else if (req.decoder_len == LEN_MAX) begin
               rsp.decoder_len_out = LEN_MAX;
            end else begin
               rsp.decoder_len_out = req.decoder_len + LEN_W'(1);
            end
         end
         stop_add = !req.block_step && stop_fin;
      end
   end

endmodule

[hw/rtl/decode_slot_stop_update.sv]
// A word in the input register moves to the result register when that register can advance.
// Throughput: one word per cycle while the result side does not stall; the input register
// and the result register form a two-stage pipeline, with the stopped count updated per word.
// Reset (synchronous, active high) empties both stages, clears the stopped count and
// returns the registers to end tokens 0, end count 1 and threshold 1024.
`include "assert_macros.svh"

module decode_slot_stop_update
   import dssu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic               s1_valid_ff;
   req_type            s1_data_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] total_in;
   logic [TOTAL_W-1:0] total_sum;
   cfg_type            cfg_ff;
   cfg_type            cfg_in;
   rsp_type            slot_rsp;
   rsp_type            rsp_in;
   logic               stop_add;
   logic               advance;
   logic               s1_fire;
   logic               s1_load;
   logic               csr_write;
   logic [REG_IDX_W-1:0] reg_idx;

   // The result register moves on when it is empty or its word is being taken.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign s1_load   = req_valid && !req_stall;

   dssu_slot u_slot (
      .req      (s1_data_ff),
      .cfg      (cfg_ff),
      .rsp      (slot_rsp),
      .stop_add (stop_add)
   );

   always_comb begin
      if (stop_add && total_ff != TOTAL_MAX) begin
         total_sum = total_ff + TOTAL_W'(1);
      end else begin
         total_sum = total_ff;
      end
      rsp_in = slot_rsp;
      rsp_in.keep_going = s1_data_ff.last_slot && (total_sum < cfg_ff.stop_threshold);
      total_in = s1_data_ff.last_slot ? '0 : total_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_fire) begin
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_data_ff <= req_data;
      end
      if (s1_fire) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Register port: always ready, writes land in the access cycle.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_idx   = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_idx)
            REG_END_TOKEN_0:    cfg_in.end_token[0]   = pwdata;
            REG_END_TOKEN_1:    cfg_in.end_token[1]   = pwdata;
            REG_END_TOKEN_2:    cfg_in.end_token[2]   = pwdata;
            REG_END_TOKEN_3:    cfg_in.end_token[3]   = pwdata;
            REG_END_COUNT:      cfg_in.end_count      = pwdata[END_CNT_W-1:0];
            REG_STOP_THRESHOLD: cfg_in.stop_threshold = pwdata[TOTAL_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.end_token      <= '0;
         cfg_ff.end_count      <= END_COUNT_RESET;
         cfg_ff.stop_threshold <= THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_END_TOKEN_0:    prdata = cfg_ff.end_token[0];
         REG_END_TOKEN_1:    prdata = cfg_ff.end_token[1];
         REG_END_TOKEN_2:    prdata = cfg_ff.end_token[2];
         REG_END_TOKEN_3:    prdata = cfg_ff.end_token[3];
         REG_END_COUNT:      prdata = CSR_DATA_W'(cfg_ff.end_count);
         REG_STOP_THRESHOLD: prdata = CSR_DATA_W'(cfg_ff.stop_threshold);
         default:            prdata = '0;
      endcase
   end

   `ASSERT_HOLDS(a_total_cleared_after_last, clock, reset,
                 (s1_fire && s1_data_ff.last_slot) |=> (total_ff == '0))
   `ASSERT_HOLDS(a_total_grows_within_batch, clock, reset,
                 (s1_fire && !s1_data_ff.last_slot) |=> (total_ff >= $past(total_ff)))
   `ASSERT_NEVER(a_keep_only_on_last, clock, reset,
                 rsp_valid_ff && rsp_data_ff.keep_going && !rsp_data_ff.last_out)
   `ASSERT_HOLDS(a_stall_only_when_full, clock, reset,
                 req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))

endmodule
